FILE: design/first_fit_block_allocator_top_defines.svh
// Assertion macros for the allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FFA_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("allocator check failed");
`define FFA_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("allocator check failed");
`endif

FILE: design/ffa_pkg.sv
`default_nettype none
package ffa_pkg;
	localparam int MaxBlocks   = 64;
	localparam int HeaderBytes = 40;
	localparam int AddrWidth   = 32;
	localparam int IdxW        = $clog2(MaxBlocks);
	localparam int CntW        = $clog2(MaxBlocks + 1);
	localparam int SizeW       = 27;
	localparam int BytesW      = 33;
	localparam int CfgW        = 32;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_REALLOC = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE = 3'd1;
	localparam logic [2:0] ST_NO_MEM   = 3'd2;
	localparam logic [2:0] ST_NULL     = 3'd3;
	localparam logic [2:0] ST_UNKNOWN  = 3'd4;

	localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
	localparam logic [1:0] REG_HEAP_LIMIT  = 2'd1;
	localparam logic [1:0] REG_MAX_REQUEST = 2'd2;

	localparam logic [SizeW-1:0] MaxRequestReset = SizeW'(100000000);

	// one table entry: size, free mark, start address
	localparam int EntW = SizeW + 1 + AddrWidth;
	typedef struct packed {
		logic [SizeW-1:0]     size;
		logic                 free;
		logic [AddrWidth-1:0] start;
	} entry_t;

	typedef struct packed {
		logic [1:0]           op;
		logic [SizeW-1:0]     request_size;
		logic [AddrWidth-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [AddrWidth-1:0] result_address;
		logic [AddrWidth-1:0] copy_source;
		logic [SizeW-1:0]     copy_length;
		logic [CntW-1:0]      free_blocks;
		logic [BytesW-1:0]    free_bytes;
		logic [CntW-1:0]      allocated_blocks;
		logic [BytesW-1:0]    allocated_bytes;
	} rsp_t;
endpackage
`default_nettype wire

FILE: design/ffa_if.sv
`default_nettype none
interface ffa_req_if;
	import ffa_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ffa_rsp_if;
	import ffa_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/ffa_ram.sv
`default_nettype none
module ffa_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: design/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [ffa_pkg::CfgW-1:0]         cfg_data,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire ffa_pkg::req_t                    req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output ffa_pkg::rsp_t                         rsp,
	output logic                                  ram_we,
	output logic [ffa_pkg::IdxW-1:0]              ram_waddr,
	output ffa_pkg::entry_t                       ram_wdata,
	output logic [ffa_pkg::IdxW-1:0]              ram_raddr,
	input  wire ffa_pkg::entry_t                  ram_rdata,
	output logic                                  busy
);
	import ffa_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_FIND     = 3'd1;  // address match walk
	localparam logic [2:0] S_FIT      = 3'd2;  // first-fit walk
	localparam logic [2:0] S_APPEND   = 3'd3;
	localparam logic [2:0] S_DONE     = 3'd4;
	localparam logic [2:0] S_FREE_OLD = 3'd7;  // release old block of a moving realloc

	logic [2:0]           state_q;
	logic [AddrWidth-1:0] heap_base_q, heap_limit_q, heap_break_q;
	logic [SizeW-1:0]     max_req_q;
	logic [CntW-1:0]      entry_count_q, free_count_q;
	logic [BytesW-1:0]    free_bytes_q, used_bytes_q;
	req_t                 req_q;
	logic [CntW-1:0]      scan_q;       // index being requested
	logic                 rd_valid_q;   // ram_rdata holds entry scan_q-1
	logic [IdxW-1:0]      rd_idx_q;
	logic                 old_hit_q;    // realloc: matched old block
	logic [IdxW-1:0]      old_idx_q;
	logic [SizeW-1:0]     old_size_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	logic [AddrWidth-1:0] payload;
	logic [AddrWidth:0]   need, room, top;
	logic                 no_mem;

	assign payload  = ram_rdata.start + AddrWidth'(HeaderBytes);
	assign need = (AddrWidth+1)'(HeaderBytes) + (AddrWidth+1)'(req_q.request_size);
	assign room = {1'b0, heap_limit_q} - {1'b0, heap_break_q};
	assign top  = {1'b0, {AddrWidth{1'b1}}} - {1'b0, heap_break_q};
	assign no_mem = (entry_count_q >= CntW'(MaxBlocks)) || (heap_break_q > heap_limit_q)
		|| (need > room) || (need > top);

	assign req_ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign ram_raddr = scan_q[IdxW-1:0];
	assign busy      = (state_q != S_IDLE);

	// walk the table reading one entry per cycle; modify and write back the matched entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			heap_base_q   <= '0;
			heap_limit_q  <= '1;
			heap_break_q  <= '0;
			max_req_q     <= MaxRequestReset;
			entry_count_q <= '0;
			free_count_q  <= '0;
			free_bytes_q  <= '0;
			used_bytes_q  <= '0;
			scan_q        <= '0;
			rd_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			ram_we        <= 1'b0;
		end else begin
			ram_we <= 1'b0;
			if (out_valid_q && rsp_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEAP_BASE: begin
						heap_base_q <= cfg_data;
						if (entry_count_q == '0) heap_break_q <= cfg_data;
					end
					REG_HEAP_LIMIT:  heap_limit_q <= cfg_data;
					REG_MAX_REQUEST: max_req_q <= cfg_data[SizeW-1:0];
					default: ;
				endcase
			end
			rd_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						req_q     <= req;
						old_hit_q <= 1'b0;
						scan_q    <= '0;
						out_q     <= '0;
						state_q   <= S_DONE;
						unique case (req.op)
							OP_ALLOC: begin
								if (req.request_size == '0 || req.request_size > max_req_q)
									out_q.status <= ST_BAD_SIZE;
								else state_q <= S_FIT;
							end
							OP_FREE: begin
								if (req.block_address == '0) out_q.status <= ST_NULL;
								else state_q <= S_FIND;
							end
							OP_REALLOC: begin
								if (req.request_size == '0 || req.request_size > max_req_q)
									out_q.status <= ST_BAD_SIZE;
								else if (req.block_address == '0) state_q <= S_FIT;
								else state_q <= S_FIND;
							end
							default: ;
						endcase
					end
				end
				S_FIND: begin
					if (rd_valid_q && payload == req_q.block_address) begin
						state_q <= S_DONE;
						if (req_q.op == OP_FREE) begin
							if (!ram_rdata.free) begin
								ram_we       <= 1'b1;
								ram_waddr    <= rd_idx_q;
								ram_wdata    <= '{size: ram_rdata.size, free: 1'b1,
									start: ram_rdata.start};
								free_count_q <= free_count_q + 1'b1;
								free_bytes_q <= free_bytes_q + BytesW'(ram_rdata.size);
							end
						end else if (ram_rdata.free) begin
							out_q.status <= ST_UNKNOWN;
						end else if (ram_rdata.size >= req_q.request_size) begin
							out_q.result_address <= req_q.block_address;
						end else begin
							old_hit_q  <= 1'b1;
							old_idx_q  <= rd_idx_q;
							old_size_q <= ram_rdata.size;
							scan_q     <= '0;
							state_q    <= S_FIT;
						end
					end else if (scan_q >= entry_count_q) begin
						if (!rd_valid_q) begin
							out_q.status <= ST_UNKNOWN;
							state_q      <= S_DONE;
						end
					end else begin
						rd_valid_q <= 1'b1;
						rd_idx_q   <= scan_q[IdxW-1:0];
						scan_q     <= scan_q + 1'b1;
					end
				end
				S_FIT: begin
					if (rd_valid_q && ram_rdata.free && ram_rdata.size >= req_q.request_size) begin
						ram_we       <= 1'b1;
						ram_waddr    <= rd_idx_q;
						ram_wdata    <= '{size: ram_rdata.size, free: 1'b0,
							start: ram_rdata.start};
						free_count_q <= free_count_q - 1'b1;
						free_bytes_q <= free_bytes_q - BytesW'(ram_rdata.size);
						out_q.result_address <= payload;
						state_q      <= S_APPEND;
						scan_q       <= '1;   // marks reuse for the finish step
					end else if (scan_q >= entry_count_q) begin
						if (!rd_valid_q) begin
							scan_q  <= '0;
							state_q <= S_APPEND;
						end
					end else begin
						rd_valid_q <= 1'b1;
						rd_idx_q   <= scan_q[IdxW-1:0];
						scan_q     <= scan_q + 1'b1;
					end
				end
				S_APPEND: begin
					// scan_q all ones: reused a block; else append at the break
					state_q <= S_DONE;
					if (scan_q != '1 && no_mem) begin
						out_q.status <= ST_NO_MEM;
						out_q.result_address <= '0;
					end else begin
						if (scan_q != '1) begin
							ram_we        <= 1'b1;
							ram_waddr     <= entry_count_q[IdxW-1:0];
							ram_wdata     <= '{size: req_q.request_size, free: 1'b0,
								start: heap_break_q};
							entry_count_q <= entry_count_q + 1'b1;
							heap_break_q  <= heap_break_q + need[AddrWidth-1:0];
							used_bytes_q  <= used_bytes_q + BytesW'(req_q.request_size);
							out_q.result_address <= heap_break_q + AddrWidth'(HeaderBytes);
						end
						if (old_hit_q) begin
							out_q.copy_source <= req_q.block_address;
							out_q.copy_length <= old_size_q;
							state_q <= S_FREE_OLD;
						end
					end
				end
				S_FREE_OLD: begin
					// old block of a moving reallocate goes free
					ram_we    <= 1'b1;
					ram_waddr <= old_idx_q;
					ram_wdata <= '{size: old_size_q, free: 1'b1,
						start: req_q.block_address - AddrWidth'(HeaderBytes)};
					free_count_q <= free_count_q + 1'b1;
					free_bytes_q <= free_bytes_q + BytesW'(old_size_q);
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_q.free_blocks      <= free_count_q;
					out_q.free_bytes       <= free_bytes_q;
					out_q.allocated_blocks <= entry_count_q;
					out_q.allocated_bytes  <= used_bytes_q;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/first_fit_block_allocator_top.sv
// Channel | Direction | Payload
// req     | in        | op, request_size, block_address
// rsp     | out       | status, addresses, copy length, running counts
// cfg     | in        | heap_base, heap_limit, max_request writes
// One transaction at a time, walking up to 64 table entries with one table RAM
// read per cycle; a moving reallocate walks twice.
// Reset clears counts and the break; the table RAM is not cleared.
// A waiting result holds the input side until it is taken.
`default_nettype none
`include "first_fit_block_allocator_top_defines.svh"
module first_fit_block_allocator_top (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [ffa_pkg::CfgW-1:0] cfg_data,
	ffa_req_if.sink                       req,
	ffa_rsp_if.source                     rsp
);
	import ffa_pkg::*;

	logic            ram_we, busy;
	logic [IdxW-1:0] ram_waddr, ram_raddr;
	entry_t          ram_wdata, ram_rdata;
	logic [EntW-1:0] rd_raw;

	assign ram_rdata = entry_t'(rd_raw);

	ffa_ram #(.Width(EntW), .Depth(MaxBlocks)) u_table (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(EntW'(ram_wdata)),
		.raddr(ram_raddr), .rdata(rd_raw)
	);

	ffa_ctrl u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.req_valid(req.valid), .req_ready(req.ready), .req(req.data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.data),
		.ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata, .busy
	);

	`FFA_ASSERT_IMPL(a_no_accept_busy, busy, !req.ready)
	`FFA_ASSERT_NEXT(a_rsp_held, rsp.valid && !rsp.ready, rsp.valid)
	`FFA_ASSERT_IMPL(a_counts, rsp.valid,
		rsp.data.free_blocks <= rsp.data.allocated_blocks)
endmodule
`default_nettype wire

FILE: dv/tb_first_fit_block_allocator_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_block_allocator_top;
	import ffa_pkg::*;

	localparam int WatchdogLimit = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;

	ffa_req_if req_ch ();
	ffa_rsp_if rsp_ch ();

	first_fit_block_allocator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// shadow allocator state
	logic [31:0] sh_base, sh_limit;
	logic [SizeW-1:0] sh_max_req;
	logic [SizeW-1:0] tbl_size [MaxBlocks];
	logic tbl_free [MaxBlocks];
	logic [31:0] tbl_start [MaxBlocks];
	int unsigned tbl_count;
	logic [63:0] brk;
	int unsigned nfree;
	logic [63:0] free_total, used_total;

	rsp_t expected_rsp_q[$];
	int unsigned error_count;
	int unsigned idle_cycles;
	bit rsp_stall_en;
	bit req_gap_en;
	bit timed_out;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic logic [31:0] payload_at(int unsigned i);
		return tbl_start[i] + 32'(HeaderBytes);
	endfunction

	function automatic int find_payload(logic [31:0] addr);
		for (int unsigned i = 0; i < tbl_count; i++)
			if (payload_at(i) == addr) return int'(i);
		return -1;
	endfunction

	function automatic logic [2:0] grant_block(logic [63:0] sz, output logic [31:0] addr);
		logic [63:0] need;
		addr = '0;
		// first fit among free blocks, no splitting
		for (int unsigned i = 0; i < tbl_count; i++) begin
			if (tbl_free[i] && 64'(tbl_size[i]) >= sz) begin
				tbl_free[i] = 1'b0;
				nfree--;
				free_total -= 64'(tbl_size[i]);
				addr = payload_at(i);
				return ST_OK;
			end
		end
		if (tbl_count >= MaxBlocks || brk > 64'(sh_limit)) return ST_NO_MEM;
		need = 64'(HeaderBytes) + sz;
		if (need > 64'(sh_limit) - brk || need > 64'hFFFF_FFFF - brk) return ST_NO_MEM;
		tbl_start[tbl_count] = brk[31:0];
		tbl_size[tbl_count] = sz[SizeW-1:0];
		tbl_free[tbl_count] = 1'b0;
		addr = payload_at(tbl_count);
		tbl_count++;
		brk += need;
		used_total += sz;
		return ST_OK;
	endfunction

	function automatic void release_block(int unsigned i);
		if (!tbl_free[i]) begin
			tbl_free[i] = 1'b1;
			nfree++;
			free_total += 64'(tbl_size[i]);
		end
	endfunction

	function automatic rsp_t predict_allocator(req_t r);
		rsp_t o;
		int idx;
		logic [31:0] a;
		logic bad_sz;
		o = '0;
		bad_sz = (r.request_size == 0) || (r.request_size > sh_max_req);
		case (r.op)
			OP_ALLOC: begin
				if (bad_sz) o.status = ST_BAD_SIZE;
				else begin
					o.status = grant_block(64'(r.request_size), a);
					o.result_address = a;
				end
			end
			OP_FREE: begin
				if (r.block_address == 0) o.status = ST_NULL;
				else begin
					idx = find_payload(r.block_address);
					if (idx < 0) o.status = ST_UNKNOWN;
					else release_block(unsigned'(idx));
				end
			end
			OP_REALLOC: begin
				if (bad_sz) o.status = ST_BAD_SIZE;
				else if (r.block_address == 0) begin
					o.status = grant_block(64'(r.request_size), a);
					o.result_address = a;
				end else begin
					idx = find_payload(r.block_address);
					if (idx < 0 || tbl_free[idx]) o.status = ST_UNKNOWN;
					else if (tbl_size[idx] >= r.request_size)
						o.result_address = r.block_address;
					else begin
						o.status = grant_block(64'(r.request_size), a);
						if (o.status == ST_OK) begin
							o.result_address = a;
							o.copy_source = r.block_address;
							o.copy_length = tbl_size[idx];
							release_block(unsigned'(idx));
						end
					end
				end
			end
			default: ;
		endcase
		if (o.status != ST_OK) o.result_address = '0;
		o.free_blocks = CntW'(nfree);
		o.free_bytes = free_total[BytesW-1:0];
		o.allocated_blocks = CntW'(tbl_count);
		o.allocated_bytes = used_total[BytesW-1:0];
		return o;
	endfunction

	// register write, only while idle
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_HEAP_BASE: begin
				sh_base = val;
				if (tbl_count == 0) brk = 64'(val);
			end
			REG_HEAP_LIMIT: sh_limit = val;
			REG_MAX_REQUEST: sh_max_req = val[SizeW-1:0];
			default: ;
		endcase
	endtask

	// one transaction on the request channel, driven on the falling edge;
	// valid drops only before an idle gap or a drain
	task automatic send_request(input logic [1:0] op, input logic [SizeW-1:0] sz,
			input logic [31:0] addr);
		req_t r;
		if (req_gap_en && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		r.op = op;
		r.request_size = sz;
		r.block_address = addr;
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		expected_rsp_q.push_back(predict_allocator(r));
		@(negedge clk);
	endtask

	task automatic drain;
		req_ch.valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(negedge clk);
		repeat (3 * MaxBlocks + 20) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_live_addr();
		if (tbl_count == 0 || $urandom_range(0, 9) == 0) return $urandom();
		return payload_at($urandom_range(0, tbl_count - 1));
	endfunction

	// response checker
	always @(posedge clk) begin
		rsp_t e;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsp_q.size() == 0) begin
				report_mismatch("unexpected response", 64'(1), 64'(0));
			end else begin
				e = expected_rsp_q.pop_front();
				if (rsp_ch.data.status !== e.status)
					report_mismatch("status", 64'(rsp_ch.data.status), 64'(e.status));
				if (rsp_ch.data.result_address !== e.result_address)
					report_mismatch("result_address", 64'(rsp_ch.data.result_address),
						64'(e.result_address));
				if (rsp_ch.data.copy_source !== e.copy_source)
					report_mismatch("copy_source", 64'(rsp_ch.data.copy_source),
						64'(e.copy_source));
				if (rsp_ch.data.copy_length !== e.copy_length)
					report_mismatch("copy_length", 64'(rsp_ch.data.copy_length),
						64'(e.copy_length));
				if (rsp_ch.data.free_blocks !== e.free_blocks)
					report_mismatch("free_blocks", 64'(rsp_ch.data.free_blocks),
						64'(e.free_blocks));
				if (rsp_ch.data.free_bytes !== e.free_bytes)
					report_mismatch("free_bytes", 64'(rsp_ch.data.free_bytes),
						64'(e.free_bytes));
				if (rsp_ch.data.allocated_blocks !== e.allocated_blocks)
					report_mismatch("allocated_blocks", 64'(rsp_ch.data.allocated_blocks),
						64'(e.allocated_blocks));
				if (rsp_ch.data.allocated_bytes !== e.allocated_bytes)
					report_mismatch("allocated_bytes", 64'(rsp_ch.data.allocated_bytes),
						64'(e.allocated_bytes));
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		rsp_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (rsp_stall_en && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WatchdogLimit && !timed_out) begin
			timed_out <= 1'b1;
			$display("status: fail");
			$finish;
		end
	end

	// directed: field extremes, every op, special cases
	task automatic test_directed;
		logic [31:0] a0, a1;
		send_request(OP_ALLOC, 0, 0);
		send_request(OP_ALLOC, SizeW'(100000001), 0);
		send_request(OP_ALLOC, '1, 32'hFFFF_FFFF);
		send_request(OP_FREE, 0, 0);
		send_request(OP_REALLOC, 0, 0);
		send_request(OP_ALLOC, 1, 0);
		send_request(OP_ALLOC, 100, 0);
		send_request(OP_ALLOC, SizeW'(100000000), 0);
		send_request(2'd3, '1, 32'hFFFF_FFFF);
		a0 = 32'(HeaderBytes);
		a1 = a0 + 32'(HeaderBytes) + 1;
		send_request(OP_FREE, 0, 32'hFFFF_FFFF);
		send_request(OP_FREE, 0, a1);
		send_request(OP_FREE, 0, a1);
		send_request(OP_REALLOC, 50, a1);
		send_request(OP_ALLOC, 50, 0);
		send_request(OP_REALLOC, 1, a0);
		send_request(OP_REALLOC, 500, a0);
		send_request(OP_REALLOC, 20, 0);
		send_request(OP_FREE, 0, a0);
		send_request(OP_ALLOC, 1, 32'h5555_5555);
		drain();
	endtask

	// configuration extremes: tiny heap, top-of-space heap limit, small request limit
	task automatic test_config_extremes;
		write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_MAX_REQUEST, 32'h07FF_FFFF);
		send_request(OP_ALLOC, '1, 0);
		send_request(OP_ALLOC, '1, 0);
		drain();
		write_reg(REG_MAX_REQUEST, 1);
		send_request(OP_ALLOC, 2, 0);
		send_request(OP_ALLOC, 1, 0);
		drain();
		write_reg(REG_HEAP_LIMIT, 0);
		send_request(OP_ALLOC, 1, 0);
		drain();
		write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
	endtask

	// random mixes in phases with different register settings
	task automatic test_random(input int unsigned n, input logic [31:0] base,
			input logic [31:0] lim, input logic [31:0] maxr, input int unsigned size_cap);
		logic [1:0] op;
		logic [SizeW-1:0] sz;
		write_reg(REG_HEAP_BASE, base);
		write_reg(REG_HEAP_LIMIT, lim);
		write_reg(REG_MAX_REQUEST, maxr);
		for (int unsigned k = 0; k < n; k++) begin
			case ($urandom_range(0, 19))
				0: op = 2'd3;
				1, 2, 3, 4, 5, 6, 7: op = OP_ALLOC;
				8, 9, 10, 11, 12, 13: op = OP_FREE;
				default: op = OP_REALLOC;
			endcase
			case ($urandom_range(0, 15))
				0: sz = 0;
				1: sz = SizeW'($urandom());
				2: sz = maxr[SizeW-1:0];
				3: sz = maxr[SizeW-1:0] + SizeW'(1);
				default: sz = SizeW'($urandom_range(1, size_cap));
			endcase
			if (op == OP_ALLOC) send_request(op, sz, $urandom_range(0, 1) ? $urandom() : 0);
			else if ($urandom_range(0, 15) == 0) send_request(op, sz, 0);
			else send_request(op, sz, pick_live_addr());
			if (k == n / 2) drain();
		end
		drain();
	endtask

	initial begin
		error_count = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		rsp_stall_en = 1'b1;
		req_gap_en = 1'b1;
		cfg_we = 1'b0;
		cfg_index = REG_HEAP_BASE;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		sh_base = '0;
		sh_limit = 32'hFFFF_FFFF;
		sh_max_req = MaxRequestReset;
		tbl_count = 0;
		brk = '0;
		nfree = 0;
		free_total = '0;
		used_total = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_extremes();
		// table is in use now; base writes only change the register
		test_random(450, 32'h0000_1000, 32'h0001_0000, 500, 600);
		test_random(450, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h07FF_FFFF, 1 << 20);
		rsp_stall_en = 1'b0;
		req_gap_en = 1'b0;
		test_random(420, 32'h8000_0000, 32'h8000_4000, 64, 80);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+design
design/ffa_pkg.sv
design/ffa_if.sv
design/ffa_ram.sv
design/ffa_ctrl.sv
design/first_fit_block_allocator_top.sv
dv/tb_first_fit_block_allocator_top.sv
